FILE: rtl/tvns_pkg.sv
// Shared types, constants and table functions of the trauma value noise shake block.
`timescale 1ns / 1ps
package tvns_pkg;

	localparam int TIME_INT_BITS_DEF = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_ADD  = 2'd1;
	localparam logic [1:0] OP_SET  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_DECAY    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_R   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SEED     = 3'd6;

	localparam logic [31:0] HASH_IDX_MUL  = 32'd374761393;
	localparam logic [31:0] HASH_SEED_MUL = 32'd668265263;
	localparam logic [31:0] HASH_MIX_MUL  = 32'd1274126177;

	typedef enum logic [4:0] {
		CMD_NOP,
		CMD_CAPTURE,
		CMD_APPLY,
		CMD_DEC_MUL,
		CMD_ADVANCE,
		CMD_LOG_INIT,
		CMD_SQ_MUL,
		CMD_SQ_WB,
		CMD_EXP_MUL,
		CMD_EXP_WB,
		CMD_PW_MUL,
		CMD_PW_WB,
		CMD_PW_FIN,
		CMD_SHAKE_LIN,
		CMD_PH_MUL_LO,
		CMD_PH_WB_LO,
		CMD_PH_MUL_HI,
		CMD_PH_WB_HI,
		CMD_SS_MUL1,
		CMD_SS_WB1,
		CMD_SS_MUL2,
		CMD_SS_WB2,
		CMD_SEED_MUL,
		CMD_SEED_WB,
		CMD_IDX_MUL,
		CMD_IDX_WB,
		CMD_HASH_MUL,
		CMD_HASH_WB,
		CMD_NOISE_MUL,
		CMD_NOISE_WB,
		CMD_SHK_MUL,
		CMD_SHK_WB
	} cmd_code_t;

	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_PEAK_MUL,
		OUT_PEAK_WB,
		OUT_EMIT
	} out_code_t;

	typedef struct packed {
		cmd_code_t   code;
		out_code_t   out_code;
		logic        zero_emit;
		logic [3:0]  cnt;
		logic        pt;
		logic [1:0]  axis;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       trauma_zero;
		logic       exp_zero;
		logic       out_free;
	} status_t;

	typedef logic [15:0][31:0] root_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] b;
		n = n_in;
		res = '0;
		b = 64'h4000_0000_0000_0000;
		for (int s = 0; s < 32; s++) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Entry j holds 2^-(2^-(j+1)) in Q0.32.
	function automatic root_tab_t root_table();
		root_tab_t t;
		logic [63:0] r;
		r = 64'h8000_0000;
		for (int j = 0; j < 16; j++) begin
			r = isqrt64(r << 32);
			t[j] = r[31:0];
		end
		return t;
	endfunction

	localparam root_tab_t ROOT_TAB = root_table();

endpackage

FILE: rtl/tvns_if.sv
// Item and result channel interfaces.
`timescale 1ns / 1ps
interface tvns_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [23:0]        elapsed;
	logic signed [17:0] amount;

	modport source(output valid, output operation, output elapsed, output amount, input ready);
	modport sink(input valid, input operation, input elapsed, input amount, output ready);
endinterface

interface tvns_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] offset_x;
	logic signed [31:0] offset_y;
	logic signed [31:0] roll;

	modport source(output valid, output offset_x, output offset_y, output roll, input ready);
	modport sink(input valid, input offset_x, input offset_y, input roll, output ready);
endinterface

FILE: rtl/trauma_value_noise_shake.sv
// Top level of the trauma driven value noise camera shake block.
`timescale 1ns / 1ps
// Add and set items produce no result. A tick with a nonzero exponent runs the
// log, exponent and power steps, then the noise steps; with the exponent at
// zero it skips the first three, and at zero trauma it emits a zero result.
// One 34 by 34 bit multiplier serves every product; the sixteen log squarings
// and sixteen power root products are most of a tick's work. One item is worked
// at a time; the result register lets a new item in while a result waits.
module trauma_value_noise_shake #(
	parameter int TIME_INT_BITS = tvns_pkg::TIME_INT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tvns_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tvns_pkg::CFG_DATA_W-1:0] cfg_data,
	tvns_item_if.sink                       item,
	tvns_result_if.source                   result
);
	import tvns_pkg::*;

	cmd_t    cmd;
	status_t status;

	tvns_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.status     (status),
		.cmd        (cmd)
	);

	tvns_datapath #(.TIME_INT_BITS(TIME_INT_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.operation (item.operation),
		.elapsed   (item.elapsed),
		.amount    (item.amount),
		.res_ready (result.ready),
		.res_valid (result.valid),
		.offset_x  (result.offset_x),
		.offset_y  (result.offset_y),
		.roll      (result.roll),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

FILE: rtl/tvns_ctrl.sv
// Sequencer that steps the shared multiplier datapath through one item.
`timescale 1ns / 1ps
module tvns_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  tvns_pkg::status_t status,
	output tvns_pkg::cmd_t    cmd
);
	import tvns_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE, S_APPLY, S_DEC_MUL, S_ADVANCE, S_BRANCH,
		S_LOG_INIT, S_SQ_MUL, S_SQ_WB, S_EXP_MUL, S_EXP_WB,
		S_PW_MUL, S_PW_WB, S_PW_FIN, S_SHAKE_LIN,
		S_PH_MUL_LO, S_PH_WB_LO, S_PH_MUL_HI, S_PH_WB_HI,
		S_SS_MUL1, S_SS_WB1, S_SS_MUL2, S_SS_WB2,
		S_SEED_MUL, S_SEED_WB, S_IDX_MUL, S_IDX_WB, S_HASH_MUL, S_HASH_WB,
		S_NOISE_MUL, S_NOISE_WB, S_SHK_MUL, S_SHK_WB, S_PEAK_MUL, S_PEAK_WB,
		S_EMIT, S_ZERO_EMIT
	} state_t;

	state_t     state_q;
	logic [3:0] cnt_q;
	logic       pt_q;
	logic [1:0] axis_q;

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.code      = CMD_NOP;
		cmd.out_code  = OUT_NONE;
		cmd.zero_emit = 1'b0;
		cmd.cnt       = cnt_q;
		cmd.pt        = pt_q;
		cmd.axis      = axis_q;
		unique case (state_q)
			S_IDLE:      if (item_valid) cmd.code = CMD_CAPTURE;
			S_APPLY:     cmd.code = CMD_APPLY;
			S_DEC_MUL:   cmd.code = CMD_DEC_MUL;
			S_ADVANCE:   cmd.code = CMD_ADVANCE;
			S_BRANCH:    cmd.code = CMD_NOP;
			S_LOG_INIT:  cmd.code = CMD_LOG_INIT;
			S_SQ_MUL:    cmd.code = CMD_SQ_MUL;
			S_SQ_WB:     cmd.code = CMD_SQ_WB;
			S_EXP_MUL:   cmd.code = CMD_EXP_MUL;
			S_EXP_WB:    cmd.code = CMD_EXP_WB;
			S_PW_MUL:    cmd.code = CMD_PW_MUL;
			S_PW_WB:     cmd.code = CMD_PW_WB;
			S_PW_FIN:    cmd.code = CMD_PW_FIN;
			S_SHAKE_LIN: cmd.code = CMD_SHAKE_LIN;
			S_PH_MUL_LO: cmd.code = CMD_PH_MUL_LO;
			S_PH_WB_LO:  cmd.code = CMD_PH_WB_LO;
			S_PH_MUL_HI: cmd.code = CMD_PH_MUL_HI;
			S_PH_WB_HI:  cmd.code = CMD_PH_WB_HI;
			S_SS_MUL1:   cmd.code = CMD_SS_MUL1;
			S_SS_WB1:    cmd.code = CMD_SS_WB1;
			S_SS_MUL2:   cmd.code = CMD_SS_MUL2;
			S_SS_WB2:    cmd.code = CMD_SS_WB2;
			S_SEED_MUL:  cmd.code = CMD_SEED_MUL;
			S_SEED_WB:   cmd.code = CMD_SEED_WB;
			S_IDX_MUL:   cmd.code = CMD_IDX_MUL;
			S_IDX_WB:    cmd.code = CMD_IDX_WB;
			S_HASH_MUL:  cmd.code = CMD_HASH_MUL;
			S_HASH_WB:   cmd.code = CMD_HASH_WB;
			S_NOISE_MUL: cmd.code = CMD_NOISE_MUL;
			S_NOISE_WB:  cmd.code = CMD_NOISE_WB;
			S_SHK_MUL:   cmd.code = CMD_SHK_MUL;
			S_SHK_WB:    cmd.code = CMD_SHK_WB;
			S_PEAK_MUL:  cmd.out_code = OUT_PEAK_MUL;
			S_PEAK_WB:   cmd.out_code = OUT_PEAK_WB;
			S_EMIT:      if (status.out_free) cmd.out_code = OUT_EMIT;
			S_ZERO_EMIT: begin
				if (status.out_free) begin
					cmd.out_code  = OUT_EMIT;
					cmd.zero_emit = 1'b1;
				end
			end
			default:     cmd.code = CMD_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pt_q    <= 1'b0;
			axis_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE:      if (item_valid) state_q <= S_APPLY;
				S_APPLY:     state_q <= (status.op == OP_TICK) ? S_DEC_MUL : S_IDLE;
				S_DEC_MUL:   state_q <= S_ADVANCE;
				S_ADVANCE:   state_q <= S_BRANCH;
				S_BRANCH: begin
					priority if (status.trauma_zero) state_q <= S_ZERO_EMIT;
					else if (status.exp_zero)        state_q <= S_SHAKE_LIN;
					else                             state_q <= S_LOG_INIT;
				end
				S_LOG_INIT: begin
					cnt_q   <= '0;
					state_q <= S_SQ_MUL;
				end
				S_SQ_MUL:    state_q <= S_SQ_WB;
				S_SQ_WB: begin
					cnt_q   <= cnt_q + 4'd1;
					state_q <= (cnt_q == 4'd15) ? S_EXP_MUL : S_SQ_MUL;
				end
				S_EXP_MUL:   state_q <= S_EXP_WB;
				S_EXP_WB: begin
					cnt_q   <= '0;
					state_q <= S_PW_MUL;
				end
				S_PW_MUL:    state_q <= S_PW_WB;
				S_PW_WB: begin
					cnt_q   <= cnt_q + 4'd1;
					state_q <= (cnt_q == 4'd15) ? S_PW_FIN : S_PW_MUL;
				end
				S_PW_FIN:    state_q <= S_PH_MUL_LO;
				S_SHAKE_LIN: state_q <= S_PH_MUL_LO;
				S_PH_MUL_LO: state_q <= S_PH_WB_LO;
				S_PH_WB_LO:  state_q <= S_PH_MUL_HI;
				S_PH_MUL_HI: state_q <= S_PH_WB_HI;
				S_PH_WB_HI:  state_q <= S_SS_MUL1;
				S_SS_MUL1:   state_q <= S_SS_WB1;
				S_SS_WB1:    state_q <= S_SS_MUL2;
				S_SS_MUL2:   state_q <= S_SS_WB2;
				S_SS_WB2: begin
					axis_q  <= '0;
					state_q <= S_SEED_MUL;
				end
				S_SEED_MUL:  state_q <= S_SEED_WB;
				S_SEED_WB: begin
					pt_q    <= 1'b0;
					state_q <= S_IDX_MUL;
				end
				S_IDX_MUL:   state_q <= S_IDX_WB;
				S_IDX_WB:    state_q <= S_HASH_MUL;
				S_HASH_MUL:  state_q <= S_HASH_WB;
				S_HASH_WB: begin
					if (!pt_q) begin
						pt_q    <= 1'b1;
						state_q <= S_IDX_MUL;
					end else begin
						state_q <= S_NOISE_MUL;
					end
				end
				S_NOISE_MUL: state_q <= S_NOISE_WB;
				S_NOISE_WB:  state_q <= S_SHK_MUL;
				S_SHK_MUL:   state_q <= S_SHK_WB;
				S_SHK_WB:    state_q <= S_PEAK_MUL;
				S_PEAK_MUL:  state_q <= S_PEAK_WB;
				S_PEAK_WB: begin
					if (axis_q == 2'd2) begin
						state_q <= S_EMIT;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_SEED_MUL;
					end
				end
				S_EMIT:      if (status.out_free) state_q <= S_IDLE;
				S_ZERO_EMIT: if (status.out_free) state_q <= S_IDLE;
				default:     state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/tvns_datapath.sv
// Registers, shared multiplier and result register of the shake block.
`timescale 1ns / 1ps
module tvns_datapath #(
	parameter int TIME_INT_BITS = tvns_pkg::TIME_INT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tvns_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tvns_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [1:0]                      operation,
	input  logic [23:0]                     elapsed,
	input  logic signed [17:0]              amount,
	input  logic                            res_ready,
	output logic                            res_valid,
	output logic signed [31:0]              offset_x,
	output logic signed [31:0]              offset_y,
	output logic signed [31:0]              roll,
	input  tvns_pkg::cmd_t                  cmd,
	output tvns_pkg::status_t               status
);
	import tvns_pkg::*;

	localparam int TW = TIME_INT_BITS + 16;

	logic [23:0]        decay_q;
	logic [15:0]        exp_q;
	logic [23:0]        freq_q;
	logic [31:0]        peak_x_q, peak_y_q, peak_r_q;
	logic [31:0]        seed_q;

	logic [TW-1:0]      time_q;
	logic [16:0]        trauma_q;

	logic [1:0]         op_q;
	logic [23:0]        dt_q;
	logic signed [17:0] amt_q;

	logic signed [67:0] prod_q;
	logic [30:0]        x_q;
	logic [15:0]        frac_q;
	logic [4:0]         lgint_q;
	logic [8:0]         k_q;
	logic [15:0]        fpw_q;
	logic [32:0]        acc_q;
	logic [16:0]        shake_q;
	logic [63:0]        phase_q;
	logic [31:0]        ff_q;
	logic [16:0]        u_q;
	logic [31:0]        sm_q;
	logic [31:0]        h_q;
	logic signed [17:0] a_q, b_q;
	logic signed [19:0] noise_q;
	logic signed [19:0] s_q;
	logic signed [31:0] work_q [3];
	logic               out_valid_q;
	logic signed [31:0] out_x_q, out_y_q, out_r_q;

	logic signed [33:0] ma, mb;
	logic [31:0]        seed_a;
	logic [31:0]        peak_sel;
	logic [31:0]        lp_idx;
	logic [31:0]        hx;
	logic [15:0]        f_ph;
	logic [17:0]        smooth_k;
	logic signed [18:0] diff;
	logic [63:0]        time_ext;
	logic [20:0]        lg;

	assign seed_a   = seed_q + 32'(cmd.axis);
	assign lp_idx   = phase_q[63:32] + 32'(cmd.pt);
	assign hx       = h_q ^ (h_q >> 13);
	assign f_ph     = phase_q[31:16];
	assign smooth_k = 18'd196608 - {1'b0, f_ph, 1'b0};
	assign diff     = {b_q[17], b_q} - {a_q[17], a_q};
	assign time_ext = 64'(time_q);
	assign lg       = {lgint_q, 16'b0} - {5'b0, frac_q};

	always_comb begin
		unique case (cmd.axis)
			2'd0:    peak_sel = peak_x_q;
			2'd1:    peak_sel = peak_y_q;
			default: peak_sel = peak_r_q;
		endcase
	end

	// Operand select for the one shared multiplier.
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (cmd.code)
			CMD_DEC_MUL:   begin ma = {10'b0, decay_q}; mb = {10'b0, dt_q}; end
			CMD_SQ_MUL:    begin ma = {3'b0, x_q}; mb = {3'b0, x_q}; end
			CMD_EXP_MUL:   begin ma = {18'b0, exp_q}; mb = {13'b0, lg}; end
			CMD_PW_MUL:    begin ma = {1'b0, acc_q}; mb = {2'b0, ROOT_TAB[cmd.cnt]}; end
			CMD_PH_MUL_LO: begin ma = {2'b0, time_ext[31:0]}; mb = {10'b0, freq_q}; end
			CMD_PH_MUL_HI: begin ma = {10'b0, time_ext[55:32]}; mb = {10'b0, freq_q}; end
			CMD_SS_MUL1:   begin ma = {18'b0, f_ph}; mb = {18'b0, f_ph}; end
			CMD_SS_MUL2:   begin ma = {2'b0, ff_q}; mb = {16'b0, smooth_k}; end
			CMD_SEED_MUL:  begin ma = {2'b0, seed_a}; mb = {2'b0, HASH_SEED_MUL}; end
			CMD_IDX_MUL:   begin ma = {2'b0, lp_idx}; mb = {2'b0, HASH_IDX_MUL}; end
			CMD_HASH_MUL:  begin ma = {2'b0, hx}; mb = {2'b0, HASH_MIX_MUL}; end
			CMD_NOISE_MUL: begin ma = {{15{diff[18]}}, diff}; mb = {17'b0, u_q}; end
			CMD_SHK_MUL:   begin ma = {17'b0, shake_q}; mb = {{14{noise_q[19]}}, noise_q}; end
			default: begin
				if (cmd.out_code == OUT_PEAK_MUL) begin
					ma = {{2{peak_sel[31]}}, peak_sel};
					mb = {{14{s_q[19]}}, s_q};
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
	end

	// Configuration and state.
	always_ff @(posedge clk or negedge arst_n) begin
		logic [48:0] dsum;
		logic [17:0] tsum;
		if (!arst_n) begin
			decay_q  <= '0;
			exp_q    <= 16'd4096;
			freq_q   <= 24'd65536;
			peak_x_q <= '0;
			peak_y_q <= '0;
			peak_r_q <= '0;
			seed_q   <= '0;
			time_q   <= '0;
			trauma_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DECAY:    decay_q  <= cfg_data[23:0];
					REG_EXPONENT: exp_q    <= cfg_data[15:0];
					REG_FREQ:     freq_q   <= cfg_data[23:0];
					REG_PEAK_X:   peak_x_q <= cfg_data;
					REG_PEAK_Y:   peak_y_q <= cfg_data;
					REG_PEAK_R:   peak_r_q <= cfg_data;
					REG_SEED:     seed_q   <= cfg_data;
					default:      ;
				endcase
			end
			dsum = {1'b0, prod_q[47:0]} + 49'd32768;
			tsum = {1'b0, trauma_q} + amt_q[17:0];
			if (cmd.code == CMD_APPLY) begin
				if (op_q == OP_ADD) begin
					if (!amt_q[17] && amt_q != 18'sd0)
						trauma_q <= (tsum > 18'd65536) ? 17'd65536 : tsum[16:0];
				end else if (op_q == OP_SET) begin
					priority if (amt_q[17])            trauma_q <= '0;
					else if (amt_q > 18'sd65536)        trauma_q <= 17'd65536;
					else                               trauma_q <= amt_q[16:0];
				end
			end
			if (cmd.code == CMD_ADVANCE && dt_q != 24'd0) begin
				time_q <= time_q + TW'(dt_q);
				if (decay_q != 24'd0)
					trauma_q <= ({16'b0, trauma_q} > dsum[48:16]) ?
						trauma_q - dsum[32:16] : '0;
			end
		end
	end

	// Work registers sequenced by the controller.
	always_ff @(posedge clk) begin
		logic [4:0]  p;
		logic [47:0] xsh;
		logic [31:0] sq;
		logic [36:0] psum;
		logic [63:0] rsum;
		logic [49:0] usum;
		logic [31:0] h2;
		logic [31:0] h3;
		logic [17:0] lv;
		logic [39:0] nr;
		logic [51:0] vs;
		logic signed [35:0] v;
		p = '0;
		for (int i = 0; i < 17; i++)
			if (trauma_q[i]) p = 5'(i);
		xsh  = {31'b0, trauma_q} << (5'd30 - p);
		sq   = prod_q[61:30];
		psum = prod_q[36:0] + 37'd2048;
		rsum = {31'b0, acc_q} + (64'd1 << (6'd15 + k_q[5:0]));
		usum = prod_q[49:0] + 50'h0_8000_0000;
		h2   = prod_q[31:0];
		h3   = h2 ^ (h2 >> 16);
		lv   = {1'b0, h3[31:15]} - 18'd65536;
		nr   = prod_q[39:0] + 40'd32768;
		vs   = prod_q[51:0] + 52'd32768;
		v    = vs[51:16];
		unique case (cmd.code)
			CMD_CAPTURE: begin
				op_q  <= operation;
				dt_q  <= elapsed;
				amt_q <= amount;
			end
			CMD_LOG_INIT: begin
				lgint_q <= 5'd16 - p;
				x_q     <= xsh[30:0];
				frac_q  <= '0;
			end
			CMD_SQ_WB: begin
				if (sq[31]) begin
					x_q    <= sq[31:1];
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					x_q    <= sq[30:0];
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			CMD_EXP_WB: begin
				k_q   <= psum[36:28];
				fpw_q <= psum[27:12];
				acc_q <= 33'h1_0000_0000;
			end
			CMD_PW_WB:     if (fpw_q[4'd15 - cmd.cnt]) acc_q <= prod_q[64:32];
			CMD_PW_FIN:    shake_q <= (k_q >= 9'd47) ? '0 : 17'(rsum >> (6'd16 + k_q[5:0]));
			CMD_SHAKE_LIN: shake_q <= trauma_q;
			CMD_PH_WB_LO:  phase_q <= prod_q[63:0];
			CMD_PH_WB_HI:  phase_q <= phase_q + {prod_q[31:0], 32'b0};
			CMD_SS_WB1:    ff_q <= prod_q[31:0];
			CMD_SS_WB2:    u_q <= usum[48:32];
			CMD_SEED_WB:   sm_q <= prod_q[31:0];
			CMD_IDX_WB:    h_q <= prod_q[31:0] + sm_q;
			CMD_HASH_WB: begin
				if (cmd.pt) b_q <= lv;
				else        a_q <= lv;
			end
			CMD_NOISE_WB:  noise_q <= nr[35:16] + {{2{a_q[17]}}, a_q};
			CMD_SHK_WB:    s_q <= nr[35:16];
			default:       ;
		endcase
		if (cmd.out_code == OUT_PEAK_WB) begin
			priority if (v > 36'sd2147483647)   work_q[cmd.axis] <= 32'sh7FFF_FFFF;
			else if (v < -36'sd2147483648)      work_q[cmd.axis] <= 32'sh8000_0000;
			else                                work_q[cmd.axis] <= v[31:0];
		end
		if (cmd.out_code == OUT_EMIT) begin
			out_x_q <= cmd.zero_emit ? '0 : work_q[0];
			out_y_q <= cmd.zero_emit ? '0 : work_q[1];
			out_r_q <= cmd.zero_emit ? '0 : work_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_code == OUT_EMIT)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign res_valid = out_valid_q;
	assign offset_x  = out_x_q;
	assign offset_y  = out_y_q;
	assign roll      = out_r_q;

	assign status.op          = op_q;
	assign status.trauma_zero = (trauma_q == 17'd0);
	assign status.exp_zero    = (exp_q == 16'd0);
	assign status.out_free    = !out_valid_q || res_ready;

endmodule

FILE: rtl/tvns_checker.sv
// Port level assertions for the shake block and their bind.
`timescale 1ns / 1ps
module tvns_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input logic               result_valid,
	input logic               result_ready,
	input logic signed [31:0] offset_x,
	input logic signed [31:0] offset_y,
	input logic signed [31:0] roll
);

	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input still ready after a transfer");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !$rose(result_valid))
		else $error("result appeared right after an input transfer");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(item_ready))
		else $error("result issued while input side was idle");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(offset_x)
			&& $stable(offset_y) && $stable(roll))
		else $error("stalled result changed");

endmodule

bind trauma_value_noise_shake tvns_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.offset_x     (result.offset_x),
	.offset_y     (result.offset_y),
	.roll         (result.roll)
);
